// ===== hdl/gtr_pkg.sv =====
`default_nettype none

package gtr_pkg;

    // Operation codes carried in the low bits of s_tuser.
    localparam logic [2:0] OP_RECEIVE = 3'd0;
    localparam logic [2:0] OP_REMOVE  = 3'd1;
    localparam logic [2:0] OP_FORWARD = 3'd2;
    localparam logic [2:0] OP_ADVANCE = 3'd3;
    localparam logic [2:0] OP_LOOKUP  = 3'd4;

    // Commands for one range list.
    typedef logic [1:0] list_cmd_t;
    localparam list_cmd_t LC_NOP    = 2'd0;
    localparam list_cmd_t LC_RECV   = 2'd1;
    localparam list_cmd_t LC_REMOVE = 2'd2;
    localparam list_cmd_t LC_DROP0  = 2'd3;

    // Source of the next cumulative ack.
    typedef logic [1:0] ack_sel_t;
    localparam ack_sel_t ACK_HOLD = 2'd0;
    localparam ack_sel_t ACK_LIST = 2'd1;
    localparam ack_sel_t ACK_SEQ  = 2'd2;
    localparam ack_sel_t ACK_HEAD = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      load;
        list_cmd_t all_cmd;
        list_cmd_t rev_cmd;
        list_cmd_t nrv_cmd;
        ack_sel_t  ack_sel;
        logic      cap_recv;
        logic      set_adv;
        logic      cap_has;
        logic      out_load;
    } gtr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [2:0] op;
        logic       isrev;
        logic       above;
        logic       ack_moved;
        logic       all_head_adj;
        logic       all_head_le;
        logic       rev_head_le;
        logic       nrv_head_le;
        logic       adv_flag;
        logic       out_free;
    } gtr_stat_t;

    // Serial-number order: a <= b when (b - a) mod 2^32 < 2^31.
    function automatic logic s_le(logic [31:0] a, logic [31:0] b);
        logic [31:0] d;
        d = b - a;
        return !d[31];
    endfunction

    function automatic logic s_gt(logic [31:0] a, logic [31:0] b);
        return (a != b) && s_le(b, a);
    endfunction

    function automatic logic s_in(logic [31:0] lo, logic [31:0] x, logic [31:0] hi);
        return s_le(lo, x) && s_le(x, hi);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/sctp_receive_gap_tracker.sv =====
// A request passes from acceptance through an execute step, any list steps, a step that
// loads the output register once it is free, and the result handshake. Receive without
// ack movement, remove, lookup and unused codes take no list steps. Forward drops head
// ranges at or below the new ack from all lists; a receive that moves the ack drops them
// from the sublists. Advance absorbs adjacent ranges into the ack, then on progress drops
// covered sublist heads. One request is processed at a time; the next is accepted while a
// result waits. Reset (asynchronous, active low) clears the ack and all three range counts.
`default_nettype none

module sctp_receive_gap_tracker #(
    parameter int MAX_RANGES = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,  // seq_num
    input  wire logic [3:0]  s_tuser,  // op[2:0], revokable[3]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,  // cum_ack[31:0], gap_count[36:32], zero[39:37]
    output logic [1:0]       m_tuser   // new_chunk[0], op_flag[1]
);
    import gtr_pkg::*;

    gtr_cmd_t  cmd;
    gtr_stat_t stat;

    // Sequencer.
    gtr_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Range lists, ack and output register.
    gtr_dp #(.MAX_RANGES(MAX_RANGES)) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .stat    (stat),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

`ifndef SYNTHESIS
    // An accepted request blocks further requests in the next cycle.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another is in progress");

    // A result is only written into a free output register.
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("result overwrote a pending result");

    // No list is touched while waiting for a request.
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (cmd.all_cmd == LC_NOP && cmd.rev_cmd == LC_NOP
                      && cmd.nrv_cmd == LC_NOP))
        else $error("list command issued while idle");
`endif

endmodule

`default_nettype wire

// ===== hdl/gtr_list.sv =====
`default_nettype none

module gtr_list #(
    parameter int MAX_RANGES = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire gtr_pkg::list_cmd_t cmd,
    input  wire logic [31:0]       r,
    input  wire logic [31:0]       ack,
    output logic [31:0]            ack_out,
    output logic                   fresh,
    output logic                   flag,
    output logic                   has,
    output logic                   head_le,
    output logic                   head_adj,
    output logic [31:0]            head_hi,
    output logic [$clog2(MAX_RANGES+1)-1:0] count
);
    import gtr_pkg::*;

    localparam int IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CW = $clog2(MAX_RANGES + 1);

    logic [31:0]   lo_reg [MAX_RANGES];
    logic [31:0]   hi_reg [MAX_RANGES];
    logic [31:0]   lo_next [MAX_RANGES];
    logic [31:0]   hi_next [MAX_RANGES];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    logic [31:0] glo [MAX_RANGES];
    logic [31:0] ghi [MAX_RANGES];
    logic [31:0] op_lo [MAX_RANGES];
    logic [31:0] op_hi [MAX_RANGES];
    logic [31:0] dr_lo [MAX_RANGES];
    logic [31:0] dr_hi [MAX_RANGES];
    logic [MAX_RANGES-1:0] rmatch;
    logic [MAX_RANGES-1:0] xmatch;
    logic [IW-1:0] ri;
    logic [IW-1:0] xi;
    logic [IW-1:0] sel;
    logic [IW-1:0] last_i;
    logic [CW-1:0] nn;
    logic [CW-1:0] dn;
    logic [31:0]   gsize;
    logic [31:0]   xsize;
    logic [31:0]   last_hi;
    logic [31:0]   tail_lo;
    logic [31:0]   ack_p1;

    // Gap bounds and range matches, evaluated for all entries at once.
    always_comb
    begin
        glo[0] = ack + 32'd1;
        for (int j = 1; j < MAX_RANGES; j++)
        begin
            glo[j] = hi_reg[j-1] + 32'd1;
        end
        for (int j = 0; j < MAX_RANGES; j++)
        begin
            ghi[j]    = lo_reg[j] - 32'd1;
            rmatch[j] = (CW'(j) < count_reg) && s_in(glo[j], r, ghi[j]);
            xmatch[j] = (CW'(j) < count_reg) && s_in(lo_reg[j], r, hi_reg[j]);
        end
    end

    // First gap that holds the number, last range that holds it.
    always_comb
    begin
        ri = '0;
        xi = '0;
        for (int j = MAX_RANGES - 1; j >= 0; j--)
        begin
            if (rmatch[j])
            begin
                ri = IW'(j);
            end
        end
        for (int j = 0; j < MAX_RANGES; j++)
        begin
            if (xmatch[j])
            begin
                xi = IW'(j);
            end
        end
    end

    assign ack_p1  = ack + 32'd1;
    assign gsize   = ghi[ri] - glo[ri] + 32'd1;
    assign xsize   = hi_reg[xi] - lo_reg[xi] + 32'd1;
    assign last_i  = IW'(count_reg - CW'(1));
    assign last_hi = hi_reg[last_i];
    assign tail_lo = (count_reg == '0) ? ack_p1 : last_hi + 32'd1;
    assign nn      = (count_reg < CW'(MAX_RANGES)) ? count_reg + CW'(1) : count_reg;
    assign dn      = (count_reg != '0) ? count_reg - CW'(1) : count_reg;
    assign sel     = (cmd == LC_REMOVE) ? xi : (cmd == LC_RECV) ? ri : '0;

    // Lists with a slot opened at, or an entry dropped from, the selected index.
    always_comb
    begin
        op_lo = lo_reg;
        op_hi = hi_reg;
        dr_lo = lo_reg;
        dr_hi = hi_reg;
        for (int j = 1; j < MAX_RANGES; j++)
        begin
            if (j > int'(sel) && j < int'(nn))
            begin
                op_lo[j] = lo_reg[j-1];
                op_hi[j] = hi_reg[j-1];
            end
        end
        for (int j = 0; j < MAX_RANGES - 1; j++)
        begin
            if (j >= int'(sel) && j + 1 < int'(count_reg))
            begin
                dr_lo[j] = lo_reg[j+1];
                dr_hi[j] = hi_reg[j+1];
            end
        end
    end

    // Next list contents for the current command.
    always_comb
    begin
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        count_next = count_reg;
        ack_out    = ack;
        fresh      = 1'b0;
        flag       = 1'b0;
        unique case (cmd)
            LC_RECV:
            begin
                if (!s_le(r, ack))
                begin
                    flag = 1'b1;
                    if (|rmatch)
                    begin
                        fresh = 1'b1;
                        if (gsize > 32'd1)
                        begin
                            if (r == ghi[ri])
                            begin
                                lo_next[ri] = r;
                            end
                            else if (r == glo[ri])
                            begin
                                if (r == ack_p1)
                                begin
                                    ack_out = ack_p1;
                                end
                                else if (ri != '0)
                                begin
                                    hi_next[ri - IW'(1)] = r;
                                end
                            end
                            else
                            begin
                                lo_next     = op_lo;
                                hi_next     = op_hi;
                                count_next  = nn;
                                lo_next[ri] = r;
                                hi_next[ri] = r;
                            end
                        end
                        else
                        begin
                            lo_next    = dr_lo;
                            hi_next    = dr_hi;
                            count_next = dn;
                            if (glo[ri] == ack_p1)
                            begin
                                ack_out = hi_reg[ri];
                            end
                            else if (ri != '0)
                            begin
                                hi_next[ri - IW'(1)] = hi_reg[ri];
                            end
                        end
                    end
                    else if (r == tail_lo)
                    begin
                        fresh = 1'b1;
                        if (r == ack_p1)
                        begin
                            ack_out = r;
                        end
                        else if (count_reg != '0)
                        begin
                            hi_next[last_i] = last_hi + 32'd1;
                        end
                    end
                    else if (count_reg == '0 || s_gt(r, last_hi + 32'd1))
                    begin
                        if (count_reg < CW'(MAX_RANGES))
                        begin
                            lo_next[IW'(count_reg)] = r;
                            hi_next[IW'(count_reg)] = r;
                            count_next = count_reg + CW'(1);
                            fresh      = 1'b1;
                        end
                    end
                end
            end
            LC_REMOVE:
            begin
                if (|xmatch)
                begin
                    if (xsize > 32'd1 && xsize <= 32'h7FFF_FFFF)
                    begin
                        if (hi_reg[xi] == r)
                        begin
                            hi_next[xi] = r - 32'd1;
                        end
                        else if (lo_reg[xi] == r)
                        begin
                            lo_next[xi] = r + 32'd1;
                        end
                        else
                        begin
                            lo_next     = op_lo;
                            hi_next     = op_hi;
                            count_next  = nn;
                            hi_next[xi] = r - 32'd1;
                            if (CW'(xi) + CW'(1) < nn)
                            begin
                                lo_next[xi + IW'(1)] = r + 32'd1;
                            end
                        end
                    end
                    else
                    begin
                        lo_next    = dr_lo;
                        hi_next    = dr_hi;
                        count_next = dn;
                    end
                end
            end
            LC_DROP0:
            begin
                lo_next    = dr_lo;
                hi_next    = dr_hi;
                count_next = dn;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // Range storage holds no reset value; only entries below the count are used.
    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Status of the first range.
    assign head_le  = (count_reg != '0) && s_le(lo_reg[0], ack);
    assign head_adj = (count_reg != '0) && (ack_p1 == lo_reg[0]);
    assign head_hi  = hi_reg[0];
    assign has      = |xmatch;
    assign count    = count_reg;

endmodule

`default_nettype wire

// ===== hdl/gtr_dp.sv =====
`default_nettype none

module gtr_dp #(
    parameter int MAX_RANGES = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire gtr_pkg::gtr_cmd_t cmd,
    output gtr_pkg::gtr_stat_t     stat,
    input  wire logic [31:0]       s_tdata,
    input  wire logic [3:0]        s_tuser,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [39:0]            m_tdata,
    output logic [1:0]             m_tuser
);
    import gtr_pkg::*;

    localparam int CW = $clog2(MAX_RANGES + 1);

    logic [31:0]   seq_reg;
    logic [2:0]    op_reg;
    logic          rev_reg;
    logic [31:0]   ack_point_reg;
    logic [31:0]   ack_point_next;
    logic          fresh_reg;
    logic          flag_reg;
    logic          out_valid_reg;
    logic [31:0]   out_ack_reg;
    logic [4:0]    out_gap_reg;
    logic          out_fresh_reg;
    logic          out_flag_reg;

    logic [31:0]   all_ack;
    logic [31:0]   rev_ack;
    logic [31:0]   nrv_ack;
    logic          all_fresh;
    logic          all_flag;
    logic          all_has;
    logic          all_le;
    logic          all_adj;
    logic [31:0]   all_hhi;
    logic [CW-1:0] all_cnt;
    logic          rev_fresh;
    logic          rev_flag;
    logic          rev_has;
    logic          rev_le;
    logic          rev_adj;
    logic [31:0]   rev_hhi;
    logic [CW-1:0] rev_cnt;
    logic          nrv_fresh;
    logic          nrv_flag;
    logic          nrv_has;
    logic          nrv_le;
    logic          nrv_adj;
    logic [31:0]   nrv_hhi;
    logic [CW-1:0] nrv_cnt;

    // Combined list; its ack result drives the cumulative ack.
    gtr_list #(.MAX_RANGES(MAX_RANGES)) u_all (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd.all_cmd),
        .r       (seq_reg),
        .ack     (ack_point_reg),
        .ack_out (all_ack),
        .fresh   (all_fresh),
        .flag    (all_flag),
        .has     (all_has),
        .head_le (all_le),
        .head_adj(all_adj),
        .head_hi (all_hhi),
        .count   (all_cnt)
    );

    // Revokable list; works on a copy of the ack.
    gtr_list #(.MAX_RANGES(MAX_RANGES)) u_rev (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd.rev_cmd),
        .r       (seq_reg),
        .ack     (ack_point_reg),
        .ack_out (rev_ack),
        .fresh   (rev_fresh),
        .flag    (rev_flag),
        .has     (rev_has),
        .head_le (rev_le),
        .head_adj(rev_adj),
        .head_hi (rev_hhi),
        .count   (rev_cnt)
    );

    // Non-revokable list; works on a copy of the ack.
    gtr_list #(.MAX_RANGES(MAX_RANGES)) u_nrv (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd.nrv_cmd),
        .r       (seq_reg),
        .ack     (ack_point_reg),
        .ack_out (nrv_ack),
        .fresh   (nrv_fresh),
        .flag    (nrv_flag),
        .has     (nrv_has),
        .head_le (nrv_le),
        .head_adj(nrv_adj),
        .head_hi (nrv_hhi),
        .count   (nrv_cnt)
    );

    // Cumulative ack source.
    always_comb
    begin
        unique case (cmd.ack_sel)
            ACK_LIST: ack_point_next = all_ack;
            ACK_SEQ:  ack_point_next = seq_reg;
            ACK_HEAD: ack_point_next = all_hhi;
            default:  ack_point_next = ack_point_reg;
        endcase
    end

    // Request payload capture.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            seq_reg <= s_tdata;
            op_reg  <= s_tuser[2:0];
            rev_reg <= s_tuser[3];
        end
        if (cmd.out_load)
        begin
            out_ack_reg   <= ack_point_reg;
            out_gap_reg   <= 5'(all_cnt);
            out_fresh_reg <= fresh_reg;
            out_flag_reg  <= flag_reg;
        end
    end

    // Ack, result flags and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_point_reg <= '0;
            fresh_reg     <= 1'b0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ack_point_reg <= ack_point_next;
            if (cmd.load)
            begin
                fresh_reg <= 1'b0;
                flag_reg  <= 1'b0;
            end
            else if (cmd.cap_recv)
            begin
                fresh_reg <= all_fresh;
                flag_reg  <= all_flag;
            end
            else if (cmd.cap_has)
            begin
                flag_reg <= all_has;
            end
            else if (cmd.set_adv)
            begin
                flag_reg <= 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Status toward the controller.
    always_comb
    begin
        stat.op           = op_reg;
        stat.isrev        = rev_reg;
        stat.above        = !s_le(seq_reg, ack_point_reg);
        stat.ack_moved    = (all_ack != ack_point_reg);
        stat.all_head_adj = all_adj;
        stat.all_head_le  = all_le;
        stat.rev_head_le  = rev_le;
        stat.nrv_head_le  = nrv_le;
        stat.adv_flag     = flag_reg;
        stat.out_free     = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_gap_reg, out_ack_reg};
    assign m_tuser  = {out_flag_reg, out_fresh_reg};

endmodule

`default_nettype wire

// ===== hdl/gtr_ctrl.sv =====
`default_nettype none

module gtr_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire gtr_pkg::gtr_stat_t stat,
    output gtr_pkg::gtr_cmd_t       cmd
);
    import gtr_pkg::*;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_EXEC    = 3'd1;
    localparam logic [2:0] ST_FWD_ALL = 3'd2;
    localparam logic [2:0] ST_FWD_SUB = 3'd3;
    localparam logic [2:0] ST_ADV     = 3'd4;
    localparam logic [2:0] ST_DONE    = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Sequencing of list commands for one request.
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        s_tready   = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (stat.op)
                    OP_RECEIVE:
                    begin
                        cmd.all_cmd  = LC_RECV;
                        cmd.ack_sel  = ACK_LIST;
                        cmd.cap_recv = 1'b1;
                        if (stat.isrev)
                        begin
                            cmd.rev_cmd = LC_RECV;
                        end
                        else
                        begin
                            cmd.nrv_cmd = LC_RECV;
                            cmd.rev_cmd = stat.above ? LC_REMOVE : LC_NOP;
                        end
                        state_next = stat.ack_moved ? ST_FWD_SUB : ST_DONE;
                    end
                    OP_REMOVE:
                    begin
                        cmd.all_cmd = LC_REMOVE;
                        cmd.rev_cmd = LC_REMOVE;
                        cmd.nrv_cmd = LC_REMOVE;
                        state_next  = ST_DONE;
                    end
                    OP_FORWARD:
                    begin
                        cmd.ack_sel = ACK_SEQ;
                        state_next  = ST_FWD_ALL;
                    end
                    OP_ADVANCE:
                    begin
                        state_next = ST_ADV;
                    end
                    OP_LOOKUP:
                    begin
                        cmd.cap_has = 1'b1;
                        state_next  = ST_DONE;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_FWD_ALL:
            begin
                cmd.all_cmd = stat.all_head_le ? LC_DROP0 : LC_NOP;
                cmd.rev_cmd = stat.rev_head_le ? LC_DROP0 : LC_NOP;
                cmd.nrv_cmd = stat.nrv_head_le ? LC_DROP0 : LC_NOP;
                if (!(stat.all_head_le || stat.rev_head_le || stat.nrv_head_le))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_FWD_SUB:
            begin
                cmd.rev_cmd = stat.rev_head_le ? LC_DROP0 : LC_NOP;
                cmd.nrv_cmd = stat.nrv_head_le ? LC_DROP0 : LC_NOP;
                if (!(stat.rev_head_le || stat.nrv_head_le))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_ADV:
            begin
                if (stat.all_head_adj)
                begin
                    cmd.all_cmd = LC_DROP0;
                    cmd.ack_sel = ACK_HEAD;
                    cmd.set_adv = 1'b1;
                end
                else
                begin
                    state_next = stat.adv_flag ? ST_FWD_SUB : ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire
